// ===== hw/rtl/csvft_pkg.sv =====
// csvft_pkg: beat types and character constants for the CSV field tokenizer.
// No dependencies; imported by csv_field_tokenizer.
`default_nettype none

package csvft_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned FIELD_W = 6;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

  // Effective ceiling on the field limit and field count cap in stop-at-empty mode
  localparam logic [FIELD_W-1:0] LIMIT_MAX     = 6'd32;
  localparam logic [FIELD_W-1:0] FIELD_IDX_MAX = 6'd63;

  // Configuration register indexes
  localparam logic CFG_SEPARATOR = 1'b0;
  localparam logic CFG_LIMIT     = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              line_last;
  } in_item_t;

  typedef struct packed {
    logic               has_char;
    logic [CHAR_W-1:0]  char_out;
    logic               field_end;
    logic [FIELD_W-1:0] field_number;
    logic               line_end;
    logic               run_last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csv_field_tokenizer.sv =====
// csv_field_tokenizer: top level, splits a byte stream into CSV fields.
// Depends on csvft_pkg for beat types and character constants.
`default_nettype none

// Usage
//   Input channel (in_valid / in_ready / in_data): one text byte per beat, with
//   line_last marking the final byte of a line. Output channel (out_valid /
//   out_ready / out_data): one result beat per field byte, field end, padding
//   field or bare line end; run_last marks the last beat caused by an input.
//   Config port (cfg_we / cfg_index / cfg_wdata): index 0 is the separator,
//   index 1 the field limit (low 6 bits). Write only while the block is idle.
//   Bytes wait in the input register; results are held in the output register.
//   Throughput: one byte per cycle while the receiver accepts and each byte
//   yields at most one result; a byte with more results, such as a line end
//   that emits padding fields under a nonzero limit, holds the input register
//   while the single output register takes one result per cycle. Bytes with no
//   result (skipped spaces, an opening quote, dropped bytes) are retired at once.
//   Reset (rst_n low, synchronous) empties both registers, restores the
//   separator to comma and the limit to 0, and returns to field start.
//   When the receiver stalls, the output register holds its beat, the input
//   register fills, and in_ready drops until results drain.
module csv_field_tokenizer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire csvft_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output csvft_pkg::out_item_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [7:0]           cfg_wdata
);
  import csvft_pkg::*;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2
  } phase_t;

  // Result slots of one input byte, in emission order
  localparam logic [2:0] SL_QUOTE = 3'd0;  // held quote turned content
  localparam logic [2:0] SL_CHAR  = 3'd1;  // the byte itself as content
  localparam logic [2:0] SL_SEPE  = 3'd2;  // field end from a separator
  localparam logic [2:0] SL_LINEE = 3'd3;  // field end from the line end
  localparam logic [2:0] SL_PAD   = 3'd4;  // run of empty padding fields
  localparam logic [2:0] SL_BARE  = 3'd5;  // bare line end
  localparam int unsigned NSLOT = 6;

  // Configuration
  logic [CHAR_W-1:0]  separator_r;
  logic [FIELD_W-1:0] field_limit_r;

  // Tokenizer state, committed when a byte has delivered all its results
  phase_t             phase_r;
  logic               quote_pending_r;
  logic               field_has_data_r;
  logic [FIELD_W-1:0] field_index_r;
  logic               line_stopped_r;

  // Input register and result sequencer
  logic               in_valid_r;
  in_item_t           in_r;
  logic [2:0]         sub_r;
  logic [FIELD_W-1:0] pad_r;

  // Output register
  logic               out_valid_r;
  out_item_t          out_r;

  // Plan for the held byte
  logic [FIELD_W-1:0] lim;
  logic               is_sep, is_quote, is_space, last;
  phase_t             ph_a;
  logic               pend_a, hd_a, stop_a;
  logic [FIELD_W-1:0] f_a, f_b, pad_cnt;
  logic               q_en, c_en, e1_en, eb_en, pad_en, bare_en, merge_end;
  logic [NSLOT-1:0]   slot_en;

  // Selection
  logic [2:0]         cur;
  logic               cur_found, higher, pad_last, final_res, has_res;
  logic               out_free, emit_go, done;
  out_item_t          res;

  assign lim      = (field_limit_r > LIMIT_MAX) ? LIMIT_MAX : field_limit_r;
  assign is_sep   = (in_r.char_in == separator_r);
  assign is_quote = (in_r.char_in == CH_QUOTE);
  assign is_space = (in_r.char_in == CH_SPACE);
  assign last     = in_r.line_last;

  always_comb begin
    logic end_a;
    ph_a    = phase_r;
    pend_a  = quote_pending_r;
    hd_a    = field_has_data_r;
    f_a     = field_index_r;
    stop_a  = line_stopped_r;
    q_en    = 1'b0;
    c_en    = 1'b0;
    e1_en   = 1'b0;
    end_a   = 1'b0;
    if (!line_stopped_r) begin
      case (phase_r)
        PH_QUOTED: begin
          if (quote_pending_r && is_sep) begin
            end_a = 1'b1;
          end else begin
            pend_a = 1'b0;
            if (quote_pending_r) begin
              q_en = 1'b1;
              hd_a = 1'b1;
            end
            if (is_quote) begin
              pend_a = !last;
            end else begin
              c_en = 1'b1;
              hd_a = 1'b1;
            end
          end
        end
        PH_PLAIN: begin
          if (is_sep) begin
            end_a = 1'b1;
          end else begin
            c_en = 1'b1;
            hd_a = 1'b1;
          end
        end
        default: begin
          // Space skip and quote start win over the separator
          if (is_space) begin
            ph_a = PH_START;
          end else if (is_quote) begin
            ph_a = PH_QUOTED;
          end else if (is_sep) begin
            end_a = 1'b1;
          end else begin
            ph_a = PH_PLAIN;
            c_en = 1'b1;
            hd_a = 1'b1;
          end
        end
      endcase
      if (end_a) begin
        ph_a   = PH_START;
        pend_a = 1'b0;
        if ((lim == '0) && !field_has_data_r) begin
          stop_a = 1'b1;
        end else begin
          e1_en  = 1'b1;
          hd_a   = 1'b0;
          f_a    = FIELD_W'(field_index_r + 1'b1);
          stop_a = (lim != '0) ? (f_a >= lim) : (f_a >= FIELD_IDX_MAX);
        end
      end
    end
  end

  // Line end: close the open field, then pad up to the limit
  always_comb begin
    eb_en     = 1'b0;
    merge_end = 1'b0;
    f_b       = f_a;
    pad_cnt   = '0;
    if (last && !stop_a) begin
      if (!((lim == '0) && !hd_a)) begin
        merge_end = q_en | c_en;
        eb_en     = !(q_en | c_en);
        f_b       = FIELD_W'(f_a + 1'b1);
        if ((lim != '0) && (lim > f_b)) begin
          pad_cnt = FIELD_W'(lim - f_b);
        end
      end
    end
    pad_en  = (pad_cnt != '0);
    bare_en = last && !(q_en | c_en | e1_en | eb_en | pad_en);
    slot_en = {bare_en, pad_en, eb_en, e1_en, c_en, q_en};
  end

  // Pick the next pending slot at or after the sequencer position
  always_comb begin
    cur       = SL_QUOTE;
    cur_found = 1'b0;
    higher    = 1'b0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (slot_en[i] && (3'(i) >= sub_r)) begin
        if (cur_found) begin
          higher = 1'b1;
        end
        cur       = 3'(i);
        cur_found = 1'b1;
      end
    end
    // higher is set when another slot above the lowest exists
  end

  assign has_res   = |slot_en;
  assign pad_last  = (pad_r == FIELD_W'(pad_cnt - 1'b1));
  assign final_res = ((cur != SL_PAD) || pad_last) && !higher;

  always_comb begin
    res.has_char     = 1'b0;
    res.char_out     = '0;
    res.field_end    = 1'b0;
    res.field_number = field_index_r;
    res.line_end     = final_res && last;
    res.run_last     = final_res;
    case (cur)
      SL_QUOTE: begin
        res.has_char  = 1'b1;
        res.char_out  = CH_QUOTE;
        res.field_end = merge_end && !c_en;
      end
      SL_CHAR: begin
        res.has_char  = 1'b1;
        res.char_out  = in_r.char_in;
        res.field_end = merge_end;
      end
      SL_SEPE: begin
        res.field_end = 1'b1;
      end
      SL_LINEE: begin
        res.field_end    = 1'b1;
        res.field_number = f_a;
      end
      SL_PAD: begin
        res.field_end    = 1'b1;
        res.field_number = FIELD_W'(f_b + pad_r);
      end
      SL_BARE: begin
        res.field_number = field_index_r;
      end
      default: begin
        res.has_char = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = in_valid_r && has_res && out_free;
  // Drop bytes with no result at once; others release on their final result
  assign done     = in_valid_r && (!has_res || (emit_go && final_res));
  assign in_ready = !in_valid_r || done;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      separator_r      <= CH_COMMA;
      field_limit_r    <= '0;
      phase_r          <= PH_START;
      quote_pending_r  <= 1'b0;
      field_has_data_r <= 1'b0;
      field_index_r    <= '0;
      line_stopped_r   <= 1'b0;
      in_valid_r       <= 1'b0;
      sub_r            <= SL_QUOTE;
      pad_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEPARATOR: separator_r   <= cfg_wdata;
          CFG_LIMIT:     field_limit_r <= cfg_wdata[FIELD_W-1:0];
          default:       separator_r   <= separator_r;
        endcase
      end

      // Output register: load a result or drain
      if (emit_go) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Advance the sequencer inside the held byte
      if (emit_go && !final_res) begin
        if ((cur == SL_PAD) && !pad_last) begin
          sub_r <= SL_PAD;
          pad_r <= FIELD_W'(pad_r + 1'b1);
        end else begin
          sub_r <= 3'(cur + 1'b1);
          pad_r <= '0;
        end
      end

      // Commit state when the byte is finished
      if (done) begin
        sub_r <= SL_QUOTE;
        pad_r <= '0;
        if (last) begin
          phase_r          <= PH_START;
          quote_pending_r  <= 1'b0;
          field_has_data_r <= 1'b0;
          field_index_r    <= '0;
          line_stopped_r   <= 1'b0;
        end else begin
          phase_r          <= ph_a;
          quote_pending_r  <= pend_a;
          field_has_data_r <= hd_a;
          field_index_r    <= f_a;
          line_stopped_r   <= stop_a;
        end
      end

      // Input register: take a new beat or empty
      if (in_ready) begin
        in_valid_r <= in_valid;
        if (in_valid) begin
          in_r <= in_data;
        end
      end
    end
  end

endmodule

`default_nettype wire
